>>> src/mcma_pkg.sv
// ----------------------------------------------------------------------------
// mcma_pkg
// Shared widths, types and constants of the multiport current averager.
// ----------------------------------------------------------------------------
`default_nettype none

package mcma_pkg;

    localparam int NUM_PORTS   = 4;
    localparam int WINDOW      = 8;
    localparam int OUT_PORTS   = 4;
    localparam int RAW_W       = 12;
    localparam int MA_W        = 12;
    localparam int TOTAL_W     = 14;
    localparam int TYPE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_REGS    = 4;
    localparam int MA_MAX      = 3000;

    // window sum, divisor/count and slot widths
    localparam int SUM_W       = $clog2(WINDOW * MA_MAX + 1);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SLOT_W      = $clog2(WINDOW);

    // divider: quotient bits retired per cycle
    localparam int DIV_BITS    = 3;
    localparam int DIV_CYCLES  = MA_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // mA conversion: q = raw*MUL/DIV, estimated as (raw*RECIP) >> RECIP_SHIFT
    localparam int COEF_W      = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = RAW_W + COEF_W;

    localparam logic [COEF_W-1:0] USB2_MUL   = COEF_W'(33000);
    localparam logic [COEF_W-1:0] USB2_DIV   = COEF_W'(61425);
    localparam logic [COEF_W-1:0] USBC_MUL   = COEF_W'(3000);
    localparam logic [COEF_W-1:0] USBC_DIV   = COEF_W'(4095);
    localparam logic [COEF_W-1:0] USB2_RECIP =
        COEF_W'((64'd33000 << RECIP_SHIFT) / 64'd61425);
    localparam logic [COEF_W-1:0] USBC_RECIP =
        COEF_W'((64'd3000 << RECIP_SHIFT) / 64'd4095);

    typedef enum logic [TYPE_W-1:0] {
        KIND_NONE = 2'd0,
        KIND_USB2 = 2'd1,
        KIND_USBC = 2'd2
    } port_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_ACC,
        ST_DIV
    } fsm_state_t;

    typedef logic [NUM_PORTS-1:0][RAW_W-1:0]  raw_vec_t;
    typedef logic [NUM_PORTS-1:0][TYPE_W-1:0] kind_vec_t;
    typedef logic [NUM_PORTS-1:0][MA_W-1:0]   ma_row_t;
    typedef logic [NUM_PORTS-1:0][SUM_W-1:0]  sum_vec_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_port0;
        logic [RAW_W-1:0] raw_port1;
        logic [RAW_W-1:0] raw_port2;
        logic [RAW_W-1:0] raw_port3;
    } mcma_in_t;

    typedef struct packed {
        logic [MA_W-1:0]    avg_port0;
        logic [MA_W-1:0]    avg_port1;
        logic [MA_W-1:0]    avg_port2;
        logic [MA_W-1:0]    avg_port3;
        logic [TOTAL_W-1:0] total_current;
    } mcma_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> src/mcma_stream_if.sv
// ----------------------------------------------------------------------------
// mcma_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcma_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> src/mcma_convert.sv
// ----------------------------------------------------------------------------
// mcma_convert
// Two-stage ADC-to-milliamp conversion, one lane per port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcma_convert
    import mcma_pkg::*;
(
    input  logic      clk,
    input  raw_vec_t  raw,
    input  kind_vec_t kind,
    output ma_row_t   ma
);

    logic [NUM_PORTS-1:0][COEF_W-1:0] recip_sel;
    logic [NUM_PORTS-1:0][COEF_W-1:0] mul_sel;
    logic [NUM_PORTS-1:0][COEF_W-1:0] div_sel;

    logic [NUM_PORTS-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_PORTS-1:0][PROD_W-1:0] num_reg;
    logic [NUM_PORTS-1:0][COEF_W-1:0] div_reg;

    logic [NUM_PORTS-1:0][MA_W-1:0]   q_est;
    logic [NUM_PORTS-1:0][PROD_W-1:0] rem;
    ma_row_t                          ma_next;
    ma_row_t                          ma_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            unique case (kind[p])
                KIND_USB2:
                begin
                    recip_sel[p] = USB2_RECIP;
                    mul_sel[p]   = USB2_MUL;
                    div_sel[p]   = USB2_DIV;
                end
                KIND_USBC:
                begin
                    recip_sel[p] = USBC_RECIP;
                    mul_sel[p]   = USBC_MUL;
                    div_sel[p]   = USBC_DIV;
                end
                default:
                begin
                    // no sensor (and the unused code) reads as zero
                    recip_sel[p] = '0;
                    mul_sel[p]   = '0;
                    div_sel[p]   = USB2_DIV;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            prod_reg[p] <= PROD_W'(raw[p]) * PROD_W'(recip_sel[p]);
            num_reg[p]  <= PROD_W'(raw[p]) * PROD_W'(mul_sel[p]);
            div_reg[p]  <= div_sel[p];
        end
    end

    // estimate is exact or one low; a single compare fixes it
    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            q_est[p]   = MA_W'(prod_reg[p] >> RECIP_SHIFT);
            rem[p]     = num_reg[p] - PROD_W'(q_est[p]) * PROD_W'(div_reg[p]);
            ma_next[p] = (rem[p] >= PROD_W'(div_reg[p])) ? q_est[p] + MA_W'(1)
                                                         : q_est[p];
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next;
    end

    assign ma = ma_reg;

endmodule

`default_nettype wire

>>> src/mcma_divider.sv
// ----------------------------------------------------------------------------
// mcma_divider
// Restoring divider, one lane per port, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcma_divider
    import mcma_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sum_vec_t         dividend,
    input  logic [CNT_W-1:0] divisor,
    output ma_row_t          quotient,
    output div_status_t      status
);

    logic [NUM_PORTS-1:0][CNT_W-1:0] rem_reg;
    logic [NUM_PORTS-1:0][CNT_W-1:0] rem_next;
    ma_row_t                         quo_reg;
    ma_row_t                         quo_next;
    logic [CNT_W-1:0]                dsr_reg;
    logic [DIV_CNT_W-1:0]            cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    // quo_reg holds the low dividend bits and fills with quotient bits
    always_comb
    begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        logic [MA_W-1:0]  q;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            r = rem_reg[p];
            q = quo_reg[p];
            for (int s = 0; s < DIV_BITS; s++)
            begin
                t = {r, q[MA_W-1]};
                q = {q[MA_W-2:0], 1'b0};
                if (t >= {1'b0, dsr_reg})
                begin
                    r    = CNT_W'(t - {1'b0, dsr_reg});
                    q[0] = 1'b1;
                end
                else
                begin
                    r = t[CNT_W-1:0];
                end
            end
            rem_next[p] = r;
            quo_next[p] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // average never exceeds MA_W bits, so the top dividend bits are below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                rem_reg[p] <= CNT_W'(dividend[p] >> MA_W);
                quo_reg[p] <= dividend[p][MA_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (dsr_reg != '0))
        else $error("divider running with zero divisor");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg[0] < dsr_reg))
        else $error("partial remainder not below divisor");

    a_div_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
`endif

endmodule

`default_nettype wire

>>> src/multiport_current_moving_average_top.sv
// A request passes the input register, two conversion stages, the window memory
// read-modify-write step and the divider (3 quotient bits per cycle) to the output
// register; a new request is taken only after its result is loaded there.
// Reset clears port types, window sums, write slot, fill flag and handshake state.
// The window memory is not cleared; until the first wrap old entries read as zero.
// ----------------------------------------------------------------------------
// multiport_current_moving_average_top
// Four-port current monitor with a per-port boxcar average over WINDOW rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module multiport_current_moving_average_top
    import mcma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TYPE_W-1:0]    cfg_data,
    mcma_stream_if.sink          samples,
    mcma_stream_if.source        averages
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [CFG_REGS-1:0][TYPE_W-1:0]  type_reg;
    logic [OUT_PORTS-1:0][RAW_W-1:0]  raw_in;
    raw_vec_t                         raw_reg;
    kind_vec_t                        kind;
    ma_row_t                          ma;

    ma_row_t                          mem [WINDOW];
    ma_row_t                          rd_row_reg;

    sum_vec_t                         sum_reg;
    sum_vec_t                         sum_next;
    logic [SLOT_W-1:0]                slot_reg;
    logic [SLOT_W-1:0]                slot_next;
    logic                             full_reg;
    logic [CNT_W-1:0]                 slot_inc;
    logic                             wrap;
    logic [CNT_W-1:0]                 div_count;

    ma_row_t                          quotient;
    div_status_t                      div_status;

    logic [OUT_PORTS-1:0][MA_W-1:0]   avg_pad;
    logic [TOTAL_W-1:0]               total;
    mcma_out_t                        out_next;
    mcma_out_t                        out_data_reg;
    logic                             out_valid_reg;

    logic accept;
    logic acc_step;
    logic out_load;

    assign accept   = samples.valid && samples.ready;
    assign acc_step = (state_reg == ST_ACC);

    always_comb
    begin
        raw_in[0] = samples.data.raw_port0;
        raw_in[1] = samples.data.raw_port1;
        raw_in[2] = samples.data.raw_port2;
        raw_in[3] = samples.data.raw_port3;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            kind[p] = type_reg[p];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done && (!out_valid_reg || averages.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0;
        end
        else if (cfg_we)
        begin
            type_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                raw_reg[p] <= raw_in[p];
            end
        end
    end

    mcma_convert u_convert (
        .clk  (clk),
        .raw  (raw_reg),
        .kind (kind),
        .ma   (ma)
    );

    // ---------------- window memory ----------------
    always_ff @(posedge clk)
    begin
        if (acc_step)
        begin
            mem[slot_reg] <= ma;
        end
        if (accept)
        begin
            rd_row_reg <= mem[slot_reg];
        end
    end

    // entries past the slot are unwritten until the first wrap: treat as zero
    always_comb
    begin
        logic [MA_W-1:0] old;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            old         = full_reg ? rd_row_reg[p] : '0;
            sum_next[p] = sum_reg[p] - SUM_W'(old) + SUM_W'(ma[p]);
        end
        slot_inc  = CNT_W'(slot_reg) + CNT_W'(1);
        wrap      = (slot_inc == CNT_W'(WINDOW));
        slot_next = wrap ? '0 : slot_inc[SLOT_W-1:0];
        div_count = (full_reg || wrap) ? CNT_W'(WINDOW) : slot_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (acc_step)
        begin
            sum_reg  <= sum_next;
            slot_reg <= slot_next;
            full_reg <= full_reg || wrap;
        end
    end

    mcma_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc_step),
        .dividend (sum_next),
        .divisor  (div_count),
        .quotient (quotient),
        .status   (div_status)
    );

    // ---------------- result register ----------------
    always_comb
    begin
        avg_pad = '0;
        total   = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            avg_pad[p] = quotient[p];
            total      = total + TOTAL_W'(quotient[p]);
        end
        out_next.avg_port0     = avg_pad[0];
        out_next.avg_port1     = avg_pad[1];
        out_next.avg_port2     = avg_pad[2];
        out_next.avg_port3     = avg_pad[3];
        out_next.total_current = total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (averages.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign averages.valid = out_valid_reg;
    assign averages.data  = out_data_reg;

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(slot_reg) < CNT_W'(WINDOW))
        else $error("write slot outside window");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(full_reg))
        else $error("window fill flag dropped");

    a_acc_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> div_status.busy)
        else $error("divider not started after accumulate");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.total_current <= TOTAL_W'(NUM_PORTS * MA_MAX)))
        else $error("total current out of range");
`endif

endmodule

`default_nettype wire
